// ===== rtl/csvd_pkg.sv =====
// ----------------------------------------------------------------------------
// csvd_pkg
// Shared constants and types for the CSV to delimited text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package csvd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned StW   = 3;

  // Configuration register indexes
  localparam logic CfgInSep  = 1'b0;
  localparam logic CfgOutSep = 1'b1;

  localparam logic [ByteW-1:0] InSepRst  = 8'd44;  // ','
  localparam logic [ByteW-1:0] OutSepRst = 8'd28;  // file separator

  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChQuote = 8'h22;

  // Parser states
  localparam logic [StW-1:0] StStart  = 3'd0;
  localparam logic [StW-1:0] StNotFld = 3'd1;
  localparam logic [StW-1:0] StQuoted = 3'd2;
  localparam logic [StW-1:0] StMayDq  = 3'd3;
  localparam logic [StW-1:0] StUnquot = 3'd4;
  localparam logic [StW-1:0] StCr     = 3'd5;
  localparam logic [StW-1:0] StLf     = 3'd6;
  localparam logic [StW-1:0] StUnused = 3'd7;  // unreachable, acts as start

  // Output produced by one input byte: zero, one or two bytes
  typedef struct packed {
    logic [1:0]       cnt;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/csv_to_delimited_converter.sv =====
// ----------------------------------------------------------------------------
// csv_to_delimited_converter
// Converts a CSV byte stream with quoted fields into plain delimited text.
//
// Channel  Dir  Handshake             Payload
// in       in   in_valid_i/in_stall_o in_byte_i, end_of_input_i
// out      out  out_valid_o/out_stall_i out_byte_o, last_o
// cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One input byte per cycle while the output is not stalled; an accepted byte is
// registered in the input stage, and its result bytes are registered in the output register.
// An input that yields two bytes holds the input side while the two-entry
// output register drains.
// Reset clears the parser to start of line and loads the default separators.
// cfg_ready_o is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_to_delimited_converter import csvd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  input  wire logic             end_of_input_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ByteW-1:0]      out_byte_o,
  output logic                  last_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_index_i,
  input  wire logic [ByteW-1:0] cfg_data_i
);

  logic             s1_valid_q, s1_valid_d;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_eoi_q;
  logic [ByteW-1:0] in_sep_q, out_sep_q;
  logic             room, fire, in_acc;
  res_t             res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = s1_valid_q && !room;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign fire        = s1_valid_q && room;
  assign s1_valid_d  = in_acc ? 1'b1 : (fire ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      in_sep_q   <= InSepRst;
      out_sep_q  <= OutSepRst;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgInSep:  in_sep_q  <= cfg_data_i;
          CfgOutSep: out_sep_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_byte_i;
      s1_eoi_q  <= end_of_input_i;
    end
  end

  csvd_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .byte_i   (s1_byte_q),
    .eoi_i    (s1_eoi_q),
    .in_sep_i (in_sep_q),
    .out_sep_i(out_sep_q),
    .res_o    (res)
  );

  csvd_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fire),
    .res_i      (res),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/csvd_fsm.sv =====
// ----------------------------------------------------------------------------
// csvd_fsm
// Parser state register and per-byte emission logic.
// ----------------------------------------------------------------------------
`default_nettype none

module csvd_fsm import csvd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic             eoi_i,
  input  wire logic [ByteW-1:0] in_sep_i,
  input  wire logic [ByteW-1:0] out_sep_i,
  output res_t                  res_o
);

  logic [StW-1:0] state_q, state_d;
  logic [StW-1:0] nx;
  res_t           res;

  always_comb begin
    nx  = state_q;
    res = '{cnt: 2'd0, b0: byte_i, b1: byte_i};
    if (eoi_i) begin
      if (state_q != StStart && state_q != StUnused) begin
        res.cnt = 2'd1;
        res.b0  = ChLf;
      end
      nx = StStart;
    end else begin
      case (state_q)
        StQuoted: begin
          if (byte_i == ChQuote) begin
            nx = StMayDq;
          end else begin
            res.cnt = 2'd1;
            nx      = StQuoted;
          end
        end
        StCr, StLf: begin
          // pending line break goes out first
          res.cnt = 2'd1;
          res.b0  = ChLf;
          if (byte_i == ChCr) begin
            nx = (state_q == StCr) ? StCr : StStart;
          end else if (byte_i == ChLf) begin
            nx = (state_q == StLf) ? StLf : StStart;
          end else if (byte_i == ChQuote) begin
            nx = StQuoted;
          end else if (byte_i == in_sep_i) begin
            res.cnt = 2'd2;
            res.b1  = out_sep_i;
            nx      = StNotFld;
          end else begin
            res.cnt = 2'd2;
            res.b1  = byte_i;
            nx      = StUnquot;
          end
        end
        default: begin
          // start of line, after separator, quote seen, unquoted field
          if (byte_i == ChCr) begin
            nx = StCr;
          end else if (byte_i == ChLf) begin
            nx = StLf;
          end else if (byte_i == ChQuote && state_q != StUnquot) begin
            if (state_q == StMayDq) begin
              res.cnt = 2'd1;
              res.b0  = ChQuote;
            end
            nx = StQuoted;
          end else if (byte_i == in_sep_i) begin
            res.cnt = 2'd1;
            res.b0  = out_sep_i;
            nx      = StNotFld;
          end else begin
            res.cnt = 2'd1;
            nx      = StUnquot;
          end
        end
      endcase
    end
  end

  assign state_d = fire_i ? nx : state_q;
  assign res_o   = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StStart;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csvd_obuf.sv =====
// ----------------------------------------------------------------------------
// csvd_obuf
// Two-entry output register; takes all bytes of one input at once.
// ----------------------------------------------------------------------------
`default_nettype none

module csvd_obuf import csvd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire res_t             res_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ByteW-1:0]      out_byte_o,
  output logic                  last_o
);

  logic [1:0]       cnt_q, cnt_d;
  logic [ByteW-1:0] b0_q, b0_d, b1_q, b1_d;
  logic             l0_q, l0_d, l1_q, l1_d;
  logic             pop;

  assign pop    = (cnt_q != 2'd0) && !out_stall_i;
  // room only when the buffer is empty or drains fully this cycle
  assign room_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    cnt_d = cnt_q;
    b0_d  = b0_q;
    b1_d  = b1_q;
    l0_d  = l0_q;
    l1_d  = l1_q;
    if (push_i) begin
      cnt_d = res_i.cnt;
      b0_d  = res_i.b0;
      b1_d  = res_i.b1;
      l0_d  = (res_i.cnt == 2'd1);
      l1_d  = 1'b1;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      b0_d  = b1_q;
      l0_d  = l1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q <= b0_d;
    b1_q <= b1_d;
    l0_q <= l0_d;
    l1_q <= l1_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_byte_o  = b0_q;
  assign last_o      = l0_q;

endmodule

`default_nettype wire
